@@ rtl/ctdn_pkg.sv @@
// Package for the countdown timer with display scan.
// Holds item and result types, register indexes, reset values and the step table.
// No dependencies.
package ctdn_pkg;

	// Field widths fixed by the item layout.
	localparam int unsigned VOTE_W = 8;
	localparam int unsigned SECS_W = 13;
	localparam int unsigned TPS_W  = 16;
	localparam int unsigned POS_W  = 2;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned MINS_W = 8;
	localparam int unsigned IN_DATA_W  = 4 * VOTE_W;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;

	// Register reset values and the hard time ceiling (99:59).
	localparam logic [TPS_W-1:0]  TPS_RESET  = 16'd1000;
	localparam logic [SECS_W-1:0] MAX_RESET  = 13'd5999;
	localparam logic [SECS_W-1:0] TIME_CAP   = 13'd5999;
	localparam logic [TPS_W-1:0]  SUBSEC_SAT = 16'hFFFF;

	// Reciprocal of 60 scaled by 2^19, rounded up; exact for every 13-bit value.
	localparam int unsigned MIN_SHIFT = 19;
	localparam logic [13:0] MIN_RECIP = 14'd8739;

	// Display positions.
	localparam logic [POS_W-1:0] POS_SEC_UNITS = 2'd0;
	localparam logic [POS_W-1:0] POS_SEC_TENS  = 2'd1;
	localparam logic [POS_W-1:0] POS_MIN_UNITS = 2'd2;
	localparam logic [POS_W-1:0] POS_MIN_TENS  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME         = 1'b1;

	// Armed flag bit positions.
	localparam int unsigned ARM_START = 0;
	localparam int unsigned ARM_PLUS  = 1;
	localparam int unsigned ARM_MINUS = 2;
	localparam int unsigned ARM_STEP  = 3;

	typedef enum logic [0:0] {
		OP_TICK   = 1'b0,
		OP_BUTTON = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [VOTE_W-1:0]  start_stop_votes;
		logic [VOTE_W-1:0]  plus_votes;
		logic [VOTE_W-1:0]  minus_votes;
		logic [VOTE_W-1:0]  step_votes;
	} in_item_t;

	// Timer state seen after one tick, handed to the display path.
	typedef struct packed {
		logic [POS_W-1:0]  digit_position;
		logic [SECS_W-1:0] seconds_left;
		logic              is_running;
	} tick_res_t;

	// Step size for step codes 0..3: 1, 10, 60, 600 seconds.
	function automatic logic [SECS_W-1:0] step_size(input logic [1:0] code);
		logic [SECS_W-1:0] s;
		unique case (code)
			2'd0: s = 13'd1;
			2'd1: s = 13'd10;
			2'd2: s = 13'd60;
			2'd3: s = 13'd600;
			default: s = 13'd1;
		endcase
		return s;
	endfunction

	// Vote sum sign tests.
	function automatic logic vote_pos(input logic [VOTE_W-1:0] v);
		return !v[VOTE_W-1] && (v != '0);
	endfunction

	function automatic logic vote_neg(input logic [VOTE_W-1:0] v);
		return v[VOTE_W-1];
	endfunction

endpackage

@@ rtl/ctdn_ctrl.sv @@
// Timer control: input register, timer state and per-item state update.
// Emits one tick result per tick word into a result register.
// Depends on ctdn_pkg.
module ctdn_ctrl import ctdn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output tick_res_t             res
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic              valid_s2;
	tick_res_t         res_s2;

	logic [TPS_W-1:0]  tps_q;
	logic [SECS_W-1:0] max_time_q;
	logic [SECS_W-1:0] secs_q;
	logic              running_q;
	logic [1:0]        step_code_q;
	logic [TPS_W-1:0]  subsec_q;
	logic [POS_W-1:0]  pos_q;
	logic [3:0]        armed_q;

	logic              go_s1;
	logic              is_tick;
	logic              free_s2;
	logic [SECS_W-1:0] secs_d;
	logic              running_d;
	logic [1:0]        step_code_d;
	logic [TPS_W-1:0]  subsec_d;
	logic [3:0]        armed_d;
	logic [SECS_W-1:0] limit;
	logic [SECS_W-1:0] step;
	logic [SECS_W:0]   sum_plus;
	logic [SECS_W-1:0] secs_mid;

	// Handshake: a button word never waits on the result side.
	assign is_tick  = (item_s1.opcode == OP_TICK);
	assign free_s2  = !valid_s2 || res_ready;
	assign go_s1    = valid_s1 && (!is_tick || free_s2);
	assign in_ready = !valid_s1 || go_s1;

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q      <= TPS_RESET;
			max_time_q <= MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICKS_PER_SECOND: tps_q <= cfg_data;
				CFG_MAX_TIME:         max_time_q <= cfg_data[SECS_W-1:0];
				default: ;
			endcase
		end
	end

	assign limit = (max_time_q > TIME_CAP) ? TIME_CAP : max_time_q;
	assign step  = step_size(step_code_q);

	// Next timer state for the word in the input register.
	always_comb begin
		secs_d      = secs_q;
		running_d   = running_q;
		step_code_d = step_code_q;
		subsec_d    = subsec_q;
		armed_d     = armed_q;
		sum_plus    = '0;
		secs_mid    = secs_q;
		if (is_tick) begin
			if (!running_q) begin
				subsec_d = '0;
			end else if (subsec_q != SUBSEC_SAT) begin
				subsec_d = subsec_q + 16'd1;
			end
			if ((secs_q != '0) && (subsec_d == tps_q)) begin
				subsec_d = '0;
				secs_d   = secs_q - 13'd1;
			end
		end else begin
			// Start/stop: a released button arms it, a pressed armed one toggles.
			if (!vote_neg(item_s1.start_stop_votes) && armed_q[ARM_START]) begin
				running_d = !running_q;
			end
			armed_d[ARM_START] = vote_neg(item_s1.start_stop_votes);

			if (!running_d) begin
				// Add step, skipped when it would pass the limit.
				sum_plus = {1'b0, secs_q} + {1'b0, step};
				if (vote_pos(item_s1.plus_votes) && armed_q[ARM_PLUS]) begin
					armed_d[ARM_PLUS] = 1'b0;
					if (sum_plus <= {1'b0, limit}) begin
						secs_mid = sum_plus[SECS_W-1:0];
					end
				end else if (vote_neg(item_s1.plus_votes)) begin
					armed_d[ARM_PLUS] = 1'b1;
				end
				// Subtract step, skipped when it would go below zero.
				secs_d = secs_mid;
				if (vote_pos(item_s1.minus_votes) && armed_q[ARM_MINUS]) begin
					armed_d[ARM_MINUS] = 1'b0;
					if (secs_mid >= step) begin
						secs_d = secs_mid - step;
					end
				end else if (vote_neg(item_s1.minus_votes)) begin
					armed_d[ARM_MINUS] = 1'b1;
				end
				// Cycle the step size.
				if (vote_pos(item_s1.step_votes) && armed_q[ARM_STEP]) begin
					armed_d[ARM_STEP] = 1'b0;
					step_code_d = step_code_q + 2'd1;
				end else if (vote_neg(item_s1.step_votes)) begin
					armed_d[ARM_STEP] = 1'b1;
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Timer state, updated as each word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q      <= '0;
			running_q   <= 1'b0;
			step_code_q <= '0;
			subsec_q    <= '0;
			pos_q       <= POS_SEC_UNITS;
			armed_q     <= '0;
		end else if (go_s1) begin
			secs_q      <= secs_d;
			running_q   <= running_d;
			step_code_q <= step_code_d;
			subsec_q    <= subsec_d;
			armed_q     <= armed_d;
			if (is_tick) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	// Result register for tick words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= go_s1 && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && go_s1 && is_tick) begin
			res_s2.digit_position <= pos_q;
			res_s2.seconds_left   <= secs_d;
			res_s2.is_running     <= running_q;
		end
	end

endmodule

@@ rtl/ctdn_disp.sv @@
// Display digit path: splits remaining seconds into minutes and seconds,
// picks the scanned digit and holds the output word. Depends on ctdn_pkg.
module ctdn_disp import ctdn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	output logic                  res_ready,
	input  tick_res_t             res,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic              valid_s3;
	tick_res_t         res_s3;
	logic [MINS_W-1:0] mins_s3;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic              load_out;
	logic              free_s3;
	logic [26:0]       prod;
	logic [SECS_W-1:0] secs_full;
	logic [5:0]        secs;
	logic [10:0]       secs_x13;
	logic [3:0]        secs_tens;
	logic [15:0]       mins_x205;
	logic [3:0]        mins_tens;
	logic [3:0]        digit;
	logic              dot;

	assign load_out  = valid_s3 && (!out_valid_q || out_ready);
	assign free_s3   = !valid_s3 || load_out;
	assign res_ready = free_s3;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Minutes by reciprocal multiplication.
	assign prod = 27'(res.seconds_left) * 27'(MIN_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && res_valid) begin
			res_s3  <= res;
			mins_s3 <= prod[MIN_SHIFT +: MINS_W];
		end
	end

	// Seconds remainder and decimal tens by small constant multiplies.
	assign secs_full = res_s3.seconds_left - ({5'b0, mins_s3} * 13'd60);
	assign secs      = secs_full[5:0];
	assign secs_x13  = 11'(secs) * 11'd13;
	assign secs_tens = {1'b0, secs_x13[9:7]};
	assign mins_x205 = 16'(mins_s3) * 16'd205;
	assign mins_tens = mins_x205[14:11];

	// Digit for the scanned position.
	always_comb begin
		dot = 1'b0;
		unique case (res_s3.digit_position)
			POS_SEC_UNITS: digit = 4'(secs - 6'(secs_tens) * 6'd10);
			POS_SEC_TENS:  digit = secs_tens;
			POS_MIN_UNITS: begin
				digit = 4'(mins_s3 - 8'(mins_tens) * 8'd10);
				dot   = 1'b1;
			end
			POS_MIN_TENS:  digit = mins_tens;
			default:       digit = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {3'b0, res_s3.is_running, res_s3.seconds_left, dot, digit,
				res_s3.digit_position};
		end
	end

endmodule

@@ rtl/countdown_timer_with_display_scan_top.sv @@
// Countdown timer with display scan: top level.
// A tick word's digit word passes the input, result, display and output registers to m_tdata.
// Throughput: one word per cycle unless the output stalls; button words produce no output word.
// The state update for each word is registered in ctdn_ctrl; the display split is two stages.
// Reset: asynchronous, active low; timer cleared, stopped, step one second, registers
// at 1000 ticks per second and 5999 seconds maximum. Depends on ctdn_pkg, ctdn_ctrl, ctdn_disp.
module countdown_timer_with_display_scan_top import ctdn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_stop_votes[7:0], plus_votes[15:8], minus_votes[23:16], step_votes[31:24]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[0]
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// digit_position[1:0], digit_value[5:2], dot_on[6], seconds_left[19:7],
	// is_running[20], zero fill [23:21]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	in_item_t  in_item;
	tick_res_t res;
	logic      res_valid;
	logic      res_ready;

	// Unpack the input word.
	assign in_item.opcode           = opcode_t'(s_tuser[0]);
	assign in_item.start_stop_votes = s_tdata[7:0];
	assign in_item.plus_votes       = s_tdata[15:8];
	assign in_item.minus_votes      = s_tdata[23:16];
	assign in_item.step_votes       = s_tdata[31:24];

	ctdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	ctdn_disp u_disp (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ test/ctdn_digit_checker.sv @@
// Checker for the countdown timer: follows the timer state from every accepted word
// and compares each digit word on the output stream. Depends on ctdn_pkg.
module ctdn_digit_checker import ctdn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [0:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    digits_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// One display digit word as the timer should emit it.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [DIGIT_W-1:0] value;
		logic               dot;
		logic [SECS_W-1:0]  secs;
		logic               run;
	} digit_word_t;

	localparam int STEP_SECS [4] = '{1, 10, 60, 600};

	// Shadow of the timer state and its two registers.
	logic [SECS_W-1:0] secs_left;
	logic              counting;
	logic [1:0]        step_sel;
	logic [TPS_W-1:0]  subsec;
	logic [POS_W-1:0]  scan;
	logic [3:0]        armed;
	logic [TPS_W-1:0]  tps_reg;
	logic [SECS_W-1:0] max_reg;
	digit_word_t       digits_due [$];
	int                words_seen;

	task automatic report_fault(input string msg);
		fail_count++;
		if (fail_count <= 40) begin
			$display("%0t ns digit check: %s", $realtime, msg);
		end
	endtask

	function automatic int settable_limit();
		return (max_reg > TIME_CAP) ? int'(TIME_CAP) : int'(max_reg);
	endfunction

	// Button evaluation: start/stop first, then add, subtract and step size,
	// the last three only while stopped. A button acts once per release.
	function automatic void apply_buttons(input logic [IN_DATA_W-1:0] w);
		int ss;
		int pl;
		int mi;
		int st;
		int stride;
		ss = $signed(w[7:0]);
		pl = $signed(w[15:8]);
		mi = $signed(w[23:16]);
		st = $signed(w[31:24]);
		stride = STEP_SECS[step_sel];
		if (ss >= 0 && armed[ARM_START]) begin
			armed[ARM_START] = 1'b0;
			counting = !counting;
		end
		if (ss < 0) begin
			armed[ARM_START] = 1'b1;
		end
		if (!counting) begin
			if (pl > 0 && armed[ARM_PLUS]) begin
				armed[ARM_PLUS] = 1'b0;
				if (int'(secs_left) + stride <= settable_limit()) begin
					secs_left = SECS_W'(int'(secs_left) + stride);
				end
			end
			if (pl < 0) begin
				armed[ARM_PLUS] = 1'b1;
			end
			if (mi > 0 && armed[ARM_MINUS]) begin
				armed[ARM_MINUS] = 1'b0;
				if (int'(secs_left) >= stride) begin
					secs_left = SECS_W'(int'(secs_left) - stride);
				end
			end
			if (mi < 0) begin
				armed[ARM_MINUS] = 1'b1;
			end
			if (st > 0 && armed[ARM_STEP]) begin
				armed[ARM_STEP] = 1'b0;
				step_sel = step_sel + 2'd1;
			end
			if (st < 0) begin
				armed[ARM_STEP] = 1'b1;
			end
		end
	endfunction

	// Tick: advance the sub-second count, take a second off when it matches,
	// then pick the digit at the current scan position.
	function automatic digit_word_t tick_digit();
		digit_word_t d;
		int unsigned s;
		int unsigned m;
		if (!counting) begin
			subsec = '0;
		end else if (subsec != SUBSEC_SAT) begin
			subsec = subsec + 1'b1;
		end
		if (secs_left != '0 && subsec == tps_reg) begin
			subsec = '0;
			secs_left = secs_left - 1'b1;
		end
		s = secs_left % 60;
		m = secs_left / 60;
		d.pos = scan;
		d.dot = (scan == POS_MIN_UNITS);
		d.secs = secs_left;
		d.run = counting;
		case (scan)
			POS_SEC_UNITS: d.value = DIGIT_W'(s % 10);
			POS_SEC_TENS:  d.value = DIGIT_W'(s / 10);
			POS_MIN_UNITS: d.value = DIGIT_W'(m % 10);
			default:       d.value = DIGIT_W'(m / 10);
		endcase
		scan = scan + 1'b1;
		return d;
	endfunction

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report_fault($sformatf("word %0d %s is %0d, expected %0d", words_seen, name, got,
				want));
		end
	endtask

	task automatic check_word(input logic [OUT_DATA_W-1:0] w);
		digit_word_t want;
		words_seen++;
		if (digits_due.size() == 0) begin
			report_fault($sformatf("word %0d (%h) arrived with nothing due", words_seen, w));
			return;
		end
		want = digits_due.pop_front();
		compare_field("digit_position", w[1:0], want.pos);
		compare_field("digit_value", w[5:2], want.value);
		compare_field("dot_on", w[6], want.dot);
		compare_field("seconds_left", w[19:7], want.secs);
		compare_field("is_running", w[20], want.run);
		compare_field("zero fill", w[23:21], 0);
	endtask

	// Sample all three ports at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_left = '0;
			counting = 1'b0;
			step_sel = '0;
			subsec = '0;
			scan = '0;
			armed = '0;
			tps_reg = TPS_RESET;
			max_reg = MAX_RESET;
			digits_due.delete();
			words_seen = 0;
			fail_count = 0;
			digits_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TICKS_PER_SECOND: tps_reg = cfg_data;
					CFG_MAX_TIME:         max_reg = cfg_data[SECS_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				check_word(m_tdata);
			end
			if (s_tvalid && s_tready) begin
				if (opcode_t'(s_tuser) == OP_BUTTON) begin
					apply_buttons(s_tdata);
				end else begin
					digits_due.push_back(tick_digit());
				end
			end
			digits_owed = digits_due.size();
		end
	end

endmodule

@@ test/countdown_timer_with_display_scan_top_tb.sv @@
// Testbench top for the countdown timer: clock, reset, stimulus and verdict.
// Drives ticks and button words, writes both registers between phases.
// Depends on ctdn_pkg, ctdn_digit_checker and countdown_timer_with_display_scan_top.
module countdown_timer_with_display_scan_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ctdn_pkg::*;

	localparam int RANDOM_WORDS = 1250;
	localparam int LATENCY_PAD  = 8;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_CHOKE,
		RX_BEAT
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    digits_owed;

	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	logic [31:0] rx_cycle = '0;
	logic        rx_relaxed = 1'b0;

	int burst_left = 0;
	int gap_left = 0;
	bit sender_steady = 1'b0;
	int words_sent = 0;

	countdown_timer_with_display_scan_top u_dut (.*);

	ctdn_digit_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: switches between stall patterns after a run of random length.
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		if (rx_relaxed) begin
			m_tready <= ($urandom_range(0, 9) != 0);
		end else begin
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
				RX_CHOKE: m_tready <= ($urandom_range(0, 7) == 0);
				default:  m_tready <= (rx_cycle[1:0] != 2'b11);
			endcase
		end
	end

	// Sends one word; called and returns at a falling edge.
	task automatic send_word(input opcode_t op, input logic [IN_DATA_W-1:0] word);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap_left = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
		end
		while (gap_left > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom();
			gap_left--;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic tick_run(input int n);
		repeat (n) send_word(OP_TICK, $urandom());
	endtask

	task automatic press(input int ss, input int pl, input int mi, input int st);
		send_word(OP_BUTTON, {8'(st), 8'(mi), 8'(pl), 8'(ss)});
	endtask

	// Vote sum with the given sign: positive, negative or zero.
	function automatic logic [VOTE_W-1:0] signed_vote(input int sgn);
		if (sgn > 0) begin
			return VOTE_W'($urandom_range(1, 100));
		end else if (sgn < 0) begin
			return VOTE_W'(0 - int'($urandom_range(1, 100)));
		end
		return '0;
	endfunction

	function automatic logic [VOTE_W-1:0] any_vote();
		int r;
		r = $urandom_range(0, 9);
		return signed_vote((r == 0) ? 0 : (r < 5) ? -1 : 1);
	endfunction

	// Lets the block drain, then waits out the pipeline.
	task automatic settle(input int tail);
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (digits_owed != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Release then press of one button, the others mostly held released.
	task automatic press_sequence();
		int target;
		int r;
		int i;
		logic [VOTE_W-1:0] v [4];
		r = $urandom_range(0, 99);
		target = (r < 20) ? ARM_START : (r < 55) ? ARM_PLUS : (r < 75) ? ARM_MINUS : ARM_STEP;
		for (i = 0; i < 4; i++) begin
			v[i] = ($urandom_range(0, 2) == 0) ? any_vote() : signed_vote(-1);
		end
		v[target] = signed_vote(-1);
		send_word(OP_BUTTON, {v[3], v[2], v[1], v[0]});
		tick_run($urandom_range(0, 3));
		for (i = 0; i < 4; i++) begin
			v[i] = ($urandom_range(0, 3) == 0) ? any_vote() : signed_vote(-1);
		end
		if (target == ARM_START && $urandom_range(0, 3) == 0) begin
			v[target] = '0;
		end else begin
			v[target] = signed_vote(1);
		end
		send_word(OP_BUTTON, {v[3], v[2], v[1], v[0]});
		// A held button must not act a second time.
		if ($urandom_range(0, 5) == 0) begin
			send_word(OP_BUTTON, {v[3], v[2], v[1], v[0]});
		end
	endtask

	// New register setting for a random phase; the first few are fixed corners.
	task automatic new_setting(input int idx);
		logic [CFG_DATA_W-1:0] tps;
		logic [SECS_W-1:0]     lim;
		int r;
		case (idx)
			0: begin tps = 16'd1; lim = 13'd8191; end
			1: begin tps = 16'd0; lim = 13'd90; end
			2: begin tps = 16'd3; lim = 13'd0; end
			3: begin tps = 16'd2; lim = 13'd1; end
			4: begin tps = 16'd1; lim = 13'd5999; end
			default: begin
				r = $urandom_range(0, 99);
				tps = (r < 60) ? CFG_DATA_W'($urandom_range(1, 4)) :
					(r < 85) ? CFG_DATA_W'($urandom_range(5, 30)) :
					(r < 90) ? 16'd0 : CFG_DATA_W'($urandom_range(1000, 65535));
				r = $urandom_range(0, 99);
				lim = (r < 50) ? SECS_W'($urandom_range(1, 240)) :
					(r < 70) ? SECS_W'($urandom_range(241, 5999)) :
					(r < 80) ? 13'd5999 : (r < 90) ? 13'd8191 :
					SECS_W'($urandom_range(0, 8191));
			end
		endcase
		settle(LATENCY_PAD);
		write_reg(CFG_TICKS_PER_SECOND, tps);
		write_reg(CFG_MAX_TIME, CFG_DATA_W'(lim));
	endtask

	initial begin
		int base;
		int phase;
		int phase_left;
		int r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: arm, add, subtract below zero, all step sizes, start, stop.
		write_reg(CFG_TICKS_PER_SECOND, 16'd2);
		tick_run(1);
		press(-100, -100, -100, -100);
		press(-1, 100, 0, 0);
		press(-1, 0, 100, 0);
		press(-1, -1, 1, -1);
		press(-1, 0, -1, 1);
		press(-1, 0, 1, -1);
		press(-1, 0, -100, 100);
		press(-1, -100, -1, -100);
		press(-1, 1, 0, 100);
		press(-1, -1, -1, -1);
		press(-1, 100, 0, 100);
		tick_run(4);
		press(0, -1, -1, -1);
		press(-100, 100, 100, 100);
		tick_run(4);
		press(100, -1, -1, -1);

		// The sub-second count climbs past a lowered period, then matches
		// again once the period is raised above it.
		settle(LATENCY_PAD);
		write_reg(CFG_TICKS_PER_SECOND, 16'd400);
		rx_relaxed <= 1'b1;
		sender_steady = 1'b1;
		press(-100, -1, -1, -1);
		press(100, -1, -1, -1);
		tick_run(60);
		settle(LATENCY_PAD);
		write_reg(CFG_TICKS_PER_SECOND, 16'd20);
		tick_run(40);
		settle(LATENCY_PAD);
		write_reg(CFG_TICKS_PER_SECOND, 16'd150);
		tick_run(60);
		press(-100, -1, -1, -1);
		press(100, -1, -1, -1);
		settle(LATENCY_PAD);
		rx_relaxed <= 1'b0;
		sender_steady = 1'b0;

		// Random phases, each with its own register setting.
		base = words_sent;
		phase = 0;
		phase_left = 0;
		while (words_sent - base < RANDOM_WORDS) begin
			if (phase_left <= 0) begin
				new_setting(phase);
				phase++;
				phase_left = $urandom_range(80, 200);
				sender_steady = ($urandom_range(0, 4) == 0);
			end
			r = $urandom_range(0, 99);
			phase_left -= 1;
			if (r < 45) begin
				press_sequence();
			end else if (r < 85) begin
				tick_run($urandom_range(1, 25));
			end else if (r < 93) begin
				send_word(OP_BUTTON, {any_vote(), any_vote(), any_vote(), any_vote()});
			end else begin
				send_word(OP_TICK, $urandom());
			end
		end

		settle(LATENCY_PAD + 4);
		if (fail_count == 0 && digits_owed == 0) begin
			$display("[countdown_timer_with_display_scan_top] OK");
		end else begin
			$display("[countdown_timer_with_display_scan_top] ERROR");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("[countdown_timer_with_display_scan_top] ERROR");
		$finish;
	end

endmodule
